// ----- rtl/dtd_pkg.sv -----
`default_nettype none

package dtd_pkg;

  localparam int DUR_W     = 39;
  localparam int STATUS_W  = 2;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int TOD_W     = 17;
  localparam int MDAY_W    = 9;

  // floor(2^36 / 100), quotient estimate is exact or one low for inputs below 2^34
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 36;
  localparam logic [RECIP_W-1:0] RECIP100 = 30'd687194767;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_YEAR = 365;
  localparam int YEAR_OFFSET   = 400;
  localparam int CENTURY       = 100;

  localparam logic [63:0] DUR_MAX = (64'd1 << DUR_W) - 64'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FIELD = 2'd1,
    ST_REVERSED  = 2'd2
  } status_e;

  function automatic logic fields_ok(
    input logic [MONTH_W-1:0] mo,
    input logic [DAY_W-1:0]   dy,
    input logic [HOUR_W-1:0]  hr,
    input logic [MIN_W-1:0]   mi,
    input logic [SEC_W-1:0]   sc
  );
    return (mo >= 4'd1) && (mo <= 4'd12) && (dy >= 5'd1) &&
           (hr <= 5'd23) && (mi <= 6'd59) && (sc <= 6'd59);
  endfunction

  // march-based month index: january and february belong to the previous year
  function automatic logic [MONTH_W-1:0] month_shift(input logic [MONTH_W-1:0] mo);
    return (mo <= 4'd2) ? mo + 4'd9 : mo - 4'd3;
  endfunction

  // days from march 1 to the first of the shifted month
  function automatic logic [MDAY_W-1:0] days_before(input logic [MONTH_W-1:0] mp);
    logic [MDAY_W-1:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/datetime_difference_seconds.sv -----
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o    first_* and last_* date and time fields
// out       output     out_valid_o / out_ready_i  duration_seconds_o, status_o
//
// five register stages: input, reciprocal multiply, day count, seconds, result.
// one item per cycle while the output is not stalled; an item moves from the input
// stage through the reciprocal multiply, day count and seconds stages to the result.
// the multiply by the reciprocal of 100 sets the depth. reset clears only the stage
// valid bits; there is no clearing pass. a stall at the output backs up stage by
// stage, so bubbles in the pipe still take new items while a result waits.

module datetime_difference_seconds #(
  parameter int YEAR_BITS = 14
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [YEAR_BITS-1:0]         first_year_i,
  input  wire  [dtd_pkg::MONTH_W-1:0]  first_month_i,
  input  wire  [dtd_pkg::DAY_W-1:0]    first_day_i,
  input  wire  [dtd_pkg::HOUR_W-1:0]   first_hour_i,
  input  wire  [dtd_pkg::MIN_W-1:0]    first_minute_i,
  input  wire  [dtd_pkg::SEC_W-1:0]    first_second_i,
  input  wire  [YEAR_BITS-1:0]         last_year_i,
  input  wire  [dtd_pkg::MONTH_W-1:0]  last_month_i,
  input  wire  [dtd_pkg::DAY_W-1:0]    last_day_i,
  input  wire  [dtd_pkg::HOUR_W-1:0]   last_hour_i,
  input  wire  [dtd_pkg::MIN_W-1:0]    last_minute_i,
  input  wire  [dtd_pkg::SEC_W-1:0]    last_second_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [dtd_pkg::DUR_W-1:0]    duration_seconds_o,
  output logic [dtd_pkg::STATUS_W-1:0] status_o
);

  import dtd_pkg::*;

  localparam int YW     = YEAR_BITS + 1;
  localparam int PW     = YW + RECIP_W;
  localparam int QW     = PW - RECIP_SHIFT;
  localparam int DW     = YW + 9;
  localparam int TW     = DW + 17;
  localparam int NSTAGE = 5;

  // stage valid bits and per-stage advance
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTAGE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // endpoint arrays: index 0 is the start, 1 the end
  logic [YEAR_BITS-1:0] yr_q [2];
  logic [MONTH_W-1:0]   mo_q [2];
  logic [DAY_W-1:0]     dy_q [2];
  logic [HOUR_W-1:0]    hr_q [2];
  logic [MIN_W-1:0]     mi_q [2];
  logic [SEC_W-1:0]     sc_q [2];

  logic [YW-1:0]        y1_d    [2];
  logic [YW-1:0]        y1_q    [2];
  logic [PW-1:0]        prod1_d [2];
  logic [PW-1:0]        prod1_q [2];
  logic [DW-1:0]        y365_d  [2];
  logic [DW-1:0]        y365_q  [2];
  logic [MONTH_W-1:0]   mp1_q   [2];
  logic [DAY_W-1:0]     dy1_q   [2];
  logic [TOD_W-1:0]     tod1_d  [2];
  logic [TOD_W-1:0]     tod1_q  [2];
  logic                 bad1_d;
  logic                 bad1_q;

  logic [DW-1:0]        days2_d [2];
  logic [DW-1:0]        days2_q [2];
  logic [TOD_W-1:0]     tod2_q  [2];
  logic                 bad2_q;

  logic [TW-1:0]        t3_d [2];
  logic [TW-1:0]        t3_q [2];
  logic                 bad3_q;

  logic [DUR_W-1:0]     dur_d;
  logic [DUR_W-1:0]     dur_q;
  status_e              status_d;
  status_e              status_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      yr_q[0] <= first_year_i;
      mo_q[0] <= first_month_i;
      dy_q[0] <= first_day_i;
      hr_q[0] <= first_hour_i;
      mi_q[0] <= first_minute_i;
      sc_q[0] <= first_second_i;
      yr_q[1] <= last_year_i;
      mo_q[1] <= last_month_i;
      dy_q[1] <= last_day_i;
      hr_q[1] <= last_hour_i;
      mi_q[1] <= last_minute_i;
      sc_q[1] <= last_second_i;
    end
    if (en[1]) begin
      bad1_q <= bad1_d;
      for (int e = 0; e < 2; e++) begin
        y1_q[e]    <= y1_d[e];
        prod1_q[e] <= prod1_d[e];
        y365_q[e]  <= y365_d[e];
        mp1_q[e]   <= month_shift(mo_q[e]);
        dy1_q[e]   <= dy_q[e];
        tod1_q[e]  <= tod1_d[e];
      end
    end
    if (en[2]) begin
      bad2_q <= bad1_q;
      for (int e = 0; e < 2; e++) begin
        days2_q[e] <= days2_d[e];
        tod2_q[e]  <= tod1_q[e];
      end
    end
    if (en[3]) begin
      bad3_q <= bad2_q;
      for (int e = 0; e < 2; e++) begin
        t3_q[e] <= t3_d[e];
      end
    end
    if (en[4]) begin
      dur_q    <= dur_d;
      status_q <= status_d;
    end
  end

  assign bad1_d = !fields_ok(mo_q[0], dy_q[0], hr_q[0], mi_q[0], sc_q[0]) ||
                  !fields_ok(mo_q[1], dy_q[1], hr_q[1], mi_q[1], sc_q[1]);

  for (genvar e = 0; e < 2; e++) begin : g_end
    logic [QW-1:0] q_est;
    logic [YW-1:0] r_full;
    logic [QW-1:0] q_fix;
    logic [7:0]    r_fix;

    // shifted year, one less for january and february
    assign y1_d[e]    = YW'(yr_q[e]) + YW'(YEAR_OFFSET) - YW'(mo_q[e] <= 4'd2);
    assign prod1_d[e] = PW'(y1_d[e]) * PW'(RECIP100);
    assign y365_d[e]  = DW'(y1_d[e]) * DW'(DAYS_PER_YEAR);
    assign tod1_d[e]  = TOD_W'(hr_q[e]) * TOD_W'(SECS_PER_HOUR) +
                        TOD_W'(mi_q[e]) * TOD_W'(SECS_PER_MIN) + TOD_W'(sc_q[e]);

    // y = 100q + r, then y/4 - y/100 + y/400 = 24q + q/4 + r/4
    assign q_est  = prod1_q[e][RECIP_SHIFT +: QW];
    assign r_full = y1_q[e] - YW'(q_est) * YW'(CENTURY);
    always_comb begin
      if (r_full >= YW'(CENTURY)) begin
        q_fix = q_est + QW'(1);
        r_fix = r_full[7:0] - 8'(CENTURY);
      end else begin
        q_fix = q_est;
        r_fix = r_full[7:0];
      end
    end

    assign days2_d[e] = y365_q[e] + DW'(q_fix) * DW'(24) + DW'(q_fix >> 2) +
                        DW'(r_fix >> 2) + DW'(days_before(mp1_q[e])) +
                        DW'(dy1_q[e]) - DW'(1);
    assign t3_d[e]    = TW'(days2_q[e]) * TW'(SECS_PER_DAY) + TW'(tod2_q[e]);
  end

  always_comb begin
    logic [TW-1:0] diff;
    diff = t3_q[1] - t3_q[0];
    if (bad3_q) begin
      status_d = ST_BAD_FIELD;
      dur_d    = '0;
    end else if (t3_q[1] < t3_q[0]) begin
      status_d = ST_REVERSED;
      dur_d    = '0;
    end else begin
      status_d = ST_OK;
      dur_d    = (diff > TW'(DUR_MAX)) ? '1 : diff[DUR_W-1:0];
    end
  end

  assign duration_seconds_o = dur_q;
  assign status_o           = status_q;

  // a status other than ok never carries a duration
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> duration_seconds_o == '0)
    else $error("nonzero duration with error status");

  // a transfer always lands in the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted item lost at input stage");

  // an item in the last compute stage reaches the output when it advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTAGE-2] && en[NSTAGE-1] |=> out_valid_o)
    else $error("item dropped before result register");

  // an invalid field flag follows its item down the pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] && bad1_q && en[2] |=> bad2_q)
    else $error("invalid field flag lost");

endmodule

`default_nettype wire
